/* rtl/stego_bit_extract_rsa_decrypt_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the stego bit extractor checks.
// ----------------------------------------------------------------------------
`ifndef STEGO_BIT_EXTRACT_RSA_DECRYPT_ASSERT_SVH
`define STEGO_BIT_EXTRACT_RSA_DECRYPT_ASSERT_SVH

// same-cycle implication
`define SBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbe assertion failed");

// next-cycle implication
`define SBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbe assertion failed");

`endif

/* rtl/sbe_pkg.sv */
// ----------------------------------------------------------------------------
// sbe_pkg
// Types and constants of the stego bit extractor with RSA decrypt.
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam logic [7:0] RSA_MODULUS_RESET = 8'd143;
    localparam logic [7:0] PRIV_EXP_RESET    = 8'd113;
    localparam logic [7:0] RSA_OFFSET        = 8'd32;
    localparam int         QUEUE_DEPTH       = 2;

    typedef enum logic [0:0] {
        CFG_MODULUS  = 1'b0,
        CFG_EXPONENT = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        OP_RAW     = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] carrier_byte;
        logic       choice_parity;
        logic       operation;
    } t_item;

    typedef struct packed {
        logic [7:0] decoded_byte;
    } t_result;

    typedef struct packed {
        t_cfg_idx   reg_index;
        logic [7:0] wdata;
    } t_cfg;

    typedef struct packed {
        logic [7:0] value;
        t_op        op;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/sbe_chan_if.sv */
// ----------------------------------------------------------------------------
// sbe_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface sbe_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sbe_front.sv */
// ----------------------------------------------------------------------------
// sbe_front
// Extract one hidden bit per carrier byte and assemble bytes MSB-first.
// ----------------------------------------------------------------------------
module sbe_front
    import sbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbe_chan_if.sink    i_item,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0] r_collector;
    logic [2:0] r_count;
    logic       w_bit;
    logic       w_last;
    logic       w_accept;
    logic [7:0] n_collector;

    assign w_last       = (r_count == 3'd7);
    assign i_item.ready = !(w_last && i_q_stat.full);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_bit        = i_item.data.choice_parity ? i_item.data.carrier_byte[0]
                                                    : i_item.data.carrier_byte[1];
    assign n_collector  = {r_collector[6:0], w_bit};

    assign o_push       = w_accept && w_last;
    assign o_job.value  = n_collector;
    assign o_job.op     = t_op'(i_item.data.operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collector <= '0;
            r_count     <= '0;
        end else if (w_accept) begin
            r_count     <= r_count + 3'd1;
            r_collector <= w_last ? 8'd0 : n_collector;
        end
    end

endmodule

/* rtl/sbe_queue.sv */
// ----------------------------------------------------------------------------
// sbe_queue
// Short job queue between the byte assembler and the decrypt sequencer.
// ----------------------------------------------------------------------------
module sbe_queue
    import sbe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/sbe_back.sv */
// ----------------------------------------------------------------------------
// sbe_back
// Emit raw bytes or run square-and-multiply with a bit-serial modulo.
// ----------------------------------------------------------------------------
module sbe_back
    import sbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [7:0]  i_modulus,
    input  logic [7:0]  i_exponent,
    output logic        o_busy,
    sbe_chan_if.source  o_result
);

    typedef enum logic [1:0] {S_IDLE, S_RED, S_POST} t_state;
    typedef enum logic [1:0] {PH_BASE, PH_SQ, PH_MUL} t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [15:0] r_acc;
    logic [7:0]  r_base;
    logic [2:0]  r_step;
    logic [2:0]  r_bit;
    logic        r_out_valid;
    logic [7:0]  r_out_data;

    logic [15:0] w_cand;
    logic [15:0] w_sq;
    logic [15:0] w_mul;
    logic [7:0]  w_final;

    assign w_cand  = {8'd0, i_modulus} << r_step;
    assign w_sq    = 16'(r_acc[7:0]) * 16'(r_acc[7:0]);
    assign w_mul   = 16'(r_acc[7:0]) * 16'(r_base);
    assign w_final = r_acc[7:0] + RSA_OFFSET;

    assign o_pop          = (r_state == S_IDLE) && !i_q_stat.empty && !r_out_valid;
    assign o_busy         = (r_state != S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data.decoded_byte = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_BASE;
            r_step      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        priority if (i_job.op == OP_RAW) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= i_job.value;
                        end else if (i_modulus < 8'd2) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= RSA_OFFSET;
                        end else begin
                            r_acc   <= {8'd0, i_job.value};
                            r_phase <= PH_BASE;
                            r_step  <= 3'd7;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (r_acc >= w_cand) begin
                        r_acc <= r_acc - w_cand;
                    end
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_step  <= 3'd7;
                    r_state <= S_RED;
                    unique case (r_phase)
                        PH_BASE: begin
                            r_base  <= r_acc[7:0];
                            r_acc   <= 16'd1;
                            r_bit   <= 3'd7;
                            r_phase <= PH_SQ;
                        end
                        PH_SQ: begin
                            if (i_exponent[r_bit]) begin
                                r_acc   <= w_mul;
                                r_phase <= PH_MUL;
                            end else if (r_bit == 3'd0) begin
                                r_out_valid <= 1'b1;
                                r_out_data  <= w_final;
                                r_state     <= S_IDLE;
                            end else begin
                                r_bit <= r_bit - 3'd1;
                                r_acc <= w_sq;
                            end
                        end
                        default: begin
                            r_phase <= PH_SQ;
                            if (r_bit == 3'd0) begin
                                r_out_valid <= 1'b1;
                                r_out_data  <= w_final;
                                r_state     <= S_IDLE;
                            end else begin
                                r_bit <= r_bit - 3'd1;
                                r_acc <= w_sq;
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/stego_bit_extract_rsa_decrypt.sv */
// Path: a raw byte is written into the job queue with its eighth carrier item and
//   then registered at the output; a decrypted byte runs the decrypt sequencer first.
// Throughput: one carrier item per cycle while the two-entry job queue has room;
//   the decrypt sequencer (8-step serial modulo per product) sets the byte rate.
// Reset: synchronous, active low; clears collector, queue and sequencer and
//   loads modulus 143 and exponent 113.
// ----------------------------------------------------------------------------
// stego_bit_extract_rsa_decrypt
// Top level: config registers, byte assembler, job queue, decrypt sequencer.
// ----------------------------------------------------------------------------
`include "stego_bit_extract_rsa_decrypt_assert.svh"

module stego_bit_extract_rsa_decrypt
    import sbe_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbe_chan_if.sink    i_item,
    sbe_chan_if.sink    i_cfg,
    sbe_chan_if.source  o_result
);

    logic [7:0] r_modulus;
    logic [7:0] r_exponent;
    logic       w_push;
    logic       w_pop;
    logic       w_busy;
    logic       w_exp_wr;
    t_job       w_job_in;
    t_job       w_job_out;
    t_q_stat    w_q_stat;

    assign i_cfg.ready = 1'b1;
    assign w_exp_wr    = i_cfg.valid && i_cfg.ready && (i_cfg.data.reg_index == CFG_EXPONENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= RSA_MODULUS_RESET;
            r_exponent <= PRIV_EXP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg.data.wdata;
                CFG_EXPONENT: r_exponent <= i_cfg.data.wdata;
            endcase
        end
    end

    sbe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    sbe_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    sbe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .i_modulus  (r_modulus),
        .i_exponent (r_exponent),
        .o_busy     (w_busy),
        .o_result   (o_result)
    );

    `SBE_ASSERT_NOW(a_push_room, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `SBE_ASSERT_NOW(a_busy_no_result, i_clk, i_rst_n, w_busy, !o_result.valid)
    `SBE_ASSERT_NEXT(a_cfg_exp, i_clk, i_rst_n, w_exp_wr, r_exponent == $past(i_cfg.data.wdata))

endmodule
